// ===== design/ahc_pkg.sv =====
package ahc_pkg;

  localparam int IM_WORD_W   = 8;
  localparam int LOAD_ADDR_W = 7;
  localparam int PC_OUT_W    = 7;
  localparam int VALUE_W     = 32;

  // Address arithmetic runs on 9 bits: enough for any depth up to 256 plus a small step.
  localparam int MOD_W       = 9;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 20;

  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_STEP  = 1'b1;

  localparam logic [IM_WORD_W-1:0] OP_LOAD  = 8'd1;
  localparam logic [IM_WORD_W-1:0] OP_ADD   = 8'd2;
  localparam logic [IM_WORD_W-1:0] OP_STORE = 8'd3;
  localparam logic [IM_WORD_W-1:0] OP_SUB   = 8'd4;
  localparam logic [IM_WORD_W-1:0] OP_IN    = 8'd5;
  localparam logic [IM_WORD_W-1:0] OP_OUT   = 8'd6;
  localparam logic [IM_WORD_W-1:0] OP_HALT  = 8'd7;
  localparam logic [IM_WORD_W-1:0] OP_JMP   = 8'd8;
  localparam logic [IM_WORD_W-1:0] OP_SKIPZ = 8'd9;
  localparam logic [IM_WORD_W-1:0] OP_SKIPG = 8'd10;
  localparam logic [IM_WORD_W-1:0] OP_SKIPL = 8'd11;

  // x mod d for a constant d, through recip = ceil(2^RECIP_SHIFT / d).
  // For x < 512 and d <= 256 the quotient estimate is exact.
  function automatic logic [MOD_W-1:0] mod_const(input logic [MOD_W-1:0]   x,
                                                 input logic [MOD_W-1:0]   d,
                                                 input logic [RECIP_W-1:0] recip);
    logic [MOD_W+RECIP_W-1:0] prod;
    logic [MOD_W-1:0]         quo;
    logic [2*MOD_W-1:0]       qd;
    prod = (MOD_W+RECIP_W)'(x) * (MOD_W+RECIP_W)'(recip);
    quo  = prod[RECIP_SHIFT +: MOD_W];
    qd   = (2*MOD_W)'(quo) * (2*MOD_W)'(d);
    return x - qd[MOD_W-1:0];
  endfunction

  // (x + inc) mod d, valid while x < d and inc <= d
  function automatic logic [MOD_W-1:0] inc_wrap(input logic [MOD_W-1:0] x,
                                                input logic [MOD_W-1:0] inc,
                                                input logic [MOD_W-1:0] d);
    logic [MOD_W-1:0] s;
    s = x + inc;
    return (s >= d) ? s - d : s;
  endfunction

endpackage

// ===== design/ahc_imem.sv =====
module ahc_imem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [ahc_pkg::IM_WORD_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr0,
  input  logic [AW-1:0]                 rd_addr1,
  output logic [ahc_pkg::IM_WORD_W-1:0] rd_data0,
  output logic [ahc_pkg::IM_WORD_W-1:0] rd_data1
);
  import ahc_pkg::*;

  logic [IM_WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  logic [IM_WORD_W-1:0] rd_data0_r;
  logic [IM_WORD_W-1:0] rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= vld_r[rd_addr0] ? mem[rd_addr0] : '0;
      rd_data1_r <= vld_r[rd_addr1] ? mem[rd_addr1] : '0;
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// ===== design/ahc_dmem.sv =====
module ahc_dmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/accumulator_harvard_cpu.sv =====
// Timing: a step word passes through instruction fetch, then data memory read and execute,
// before its result is registered; a program write or a HALT step retires from the fetch state.
// Throughput: one program write per cycle while the output is not stalled; the next word is
// accepted on the cycle the current one retires, since its fetch needs the updated PC.
// Reset (synchronous, rst_n low): PC and accumulator cleared, both memories read as zero
// through per-entry valid bits, so no clearing pass is needed.
module accumulator_harvard_cpu #(
  parameter int PROGRAM_DEPTH = 128,
  parameter int DATA_DEPTH    = 16,
  parameter int ACC_WIDTH     = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic [ahc_pkg::LOAD_ADDR_W-1:0]       in_load_address,
  input  logic [ahc_pkg::IM_WORD_W-1:0]         in_program_word,
  input  logic signed [ahc_pkg::VALUE_W-1:0]    in_in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ahc_pkg::PC_OUT_W-1:0]          out_pc_now,
  output logic signed [ahc_pkg::VALUE_W-1:0]    out_acc_now,
  output logic                                  out_out_valid,
  output logic signed [ahc_pkg::VALUE_W-1:0]    out_out_value,
  output logic                                  out_halted,
  output logic                                  out_bad_opcode
);
  import ahc_pkg::*;

  localparam int PW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int DW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [MOD_W-1:0]   PDEP = MOD_W'(PROGRAM_DEPTH);
  localparam logic [MOD_W-1:0]   DDEP = MOD_W'(DATA_DEPTH);
  localparam logic [RECIP_W-1:0] PREC =
    RECIP_W'((2**RECIP_SHIFT + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH);
  localparam logic [RECIP_W-1:0] DREC =
    RECIP_W'((2**RECIP_SHIFT + DATA_DEPTH - 1) / DATA_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           pc_r, pc_nxt;
  logic [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                    step_r;
  logic signed [VALUE_W-1:0] value_r;

  logic [IM_WORD_W-1:0]    im_op, im_arg;
  logic [PW-1:0]           im_rd_addr1, im_wr_addr;
  logic                    im_wr_en;

  logic [IM_WORD_W-1:0]    op_r;
  logic [PW-1:0]           pc2_r, pc4_r, jmp_r;
  logic [DW-1:0]           da_r;
  logic [PW-1:0]           pc2_c, pc4_c, jmp_c;
  logic [DW-1:0]           da_c;
  logic [ACC_WIDTH-1:0]    dm_rdata;
  logic                    dm_we, dm_rd_en;

  logic                    is_halt, fetch_done, finish, out_free, in_accept;
  logic                    res_out_valid, res_halted, res_bad;
  logic [VALUE_W-1:0]      res_out_value;

  logic                    out_valid_r;
  logic [PC_OUT_W-1:0]     out_pc_now_r;
  logic [VALUE_W-1:0]      out_acc_now_r, out_out_value_r;
  logic                    out_out_valid_r, out_halted_r, out_bad_r;

  // ---- handshake ----
  assign out_free   = !out_valid_r || !out_stall;
  assign is_halt    = step_r && (im_op == OP_HALT);
  assign fetch_done = !step_r || is_halt;
  assign finish     = out_free && (((state_r == ST_FETCH) && fetch_done) ||
                                   (state_r == ST_EXEC));
  assign in_stall   = !((state_r == ST_IDLE) || finish);
  assign in_accept  = in_valid && !in_stall;

  // ---- instruction memory: program writes and fetch at the next PC ----
  assign im_wr_en    = in_accept && (in_operation == OPER_WRITE);
  assign im_wr_addr  = PW'(mod_const(MOD_W'(in_load_address), PDEP, PREC));
  assign im_rd_addr1 = PW'(inc_wrap(MOD_W'(pc_nxt), MOD_W'(1), PDEP));

  ahc_imem #(
    .DEPTH (PROGRAM_DEPTH),
    .AW    (PW)
  ) u_imem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (im_wr_en),
    .wr_addr  (im_wr_addr),
    .wr_data  (in_program_word),
    .rd_en    (in_accept),
    .rd_addr0 (pc_nxt),
    .rd_addr1 (im_rd_addr1),
    .rd_data0 (im_op),
    .rd_data1 (im_arg)
  );

  // ---- decode in the fetch cycle ----
  assign pc2_c = PW'(inc_wrap(MOD_W'(pc_r), MOD_W'(2), PDEP));
  assign pc4_c = PW'(inc_wrap(MOD_W'(pc2_c), MOD_W'(2), PDEP));
  assign jmp_c = PW'(mod_const(MOD_W'(im_arg), PDEP, PREC));
  assign da_c  = DW'(mod_const(MOD_W'(im_arg), DDEP, DREC));

  assign dm_rd_en = (state_r == ST_FETCH) && !fetch_done;

  // only one item is in flight, so a store always lands before the next load reads
  ahc_dmem #(
    .DEPTH (DATA_DEPTH),
    .AW    (DW),
    .W     (ACC_WIDTH)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dm_we && finish),
    .wr_addr (da_r),
    .wr_data (acc_r),
    .rd_en   (dm_rd_en),
    .rd_addr (da_c),
    .rd_data (dm_rdata)
  );

  // ---- execute ----
  always_comb begin
    acc_nxt       = acc_r;
    pc_nxt        = pc_r;
    dm_we         = 1'b0;
    res_out_valid = 1'b0;
    res_out_value = '0;
    res_halted    = 1'b0;
    res_bad       = 1'b0;
    unique case (state_r)
      ST_FETCH: begin
        res_halted = is_halt;
      end
      ST_EXEC: begin
        pc_nxt = pc2_r;
        unique case (op_r)
          OP_LOAD:  acc_nxt = dm_rdata;
          OP_ADD:   acc_nxt = acc_r + dm_rdata;
          OP_STORE: dm_we = 1'b1;
          OP_SUB:   acc_nxt = acc_r - dm_rdata;
          OP_IN:    acc_nxt = ACC_WIDTH'(value_r);
          OP_OUT: begin
            res_out_valid = 1'b1;
            res_out_value = VALUE_W'(signed'(acc_r));
          end
          OP_JMP:   pc_nxt = jmp_r;
          OP_SKIPZ: begin
            if (acc_r == '0) pc_nxt = pc4_r;
          end
          OP_SKIPG: begin
            if ((acc_r != '0) && !acc_r[ACC_WIDTH-1]) pc_nxt = pc4_r;
          end
          OP_SKIPL: begin
            if (acc_r[ACC_WIDTH-1]) pc_nxt = pc4_r;
          end
          default:  res_bad = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (!fetch_done) begin
          state_nxt = ST_EXEC;
        end else if (finish) begin
          state_nxt = in_accept ? ST_FETCH : ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (finish) state_nxt = in_accept ? ST_FETCH : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        pc_r  <= pc_nxt;
        acc_r <= acc_nxt;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      step_r  <= (in_operation == OPER_STEP);
      value_r <= in_in_value;
    end
    if (state_r == ST_FETCH) begin
      op_r  <= im_op;
      pc2_r <= pc2_c;
      pc4_r <= pc4_c;
      jmp_r <= jmp_c;
      da_r  <= da_c;
    end
    if (finish) begin
      out_pc_now_r    <= PC_OUT_W'(pc_nxt);
      out_acc_now_r   <= VALUE_W'(signed'(acc_nxt));
      out_out_valid_r <= res_out_valid;
      out_out_value_r <= res_out_value;
      out_halted_r    <= res_halted;
      out_bad_r       <= res_bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pc_now     = out_pc_now_r;
  assign out_acc_now    = out_acc_now_r;
  assign out_out_valid  = out_out_valid_r;
  assign out_out_value  = out_out_value_r;
  assign out_halted     = out_halted_r;
  assign out_bad_opcode = out_bad_r;

  // ---- checks ----
  // architectural state only moves when a word retires into the output register
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pc_now_r == PC_OUT_W'(pc_r)) &&
                    (out_acc_now_r == VALUE_W'(signed'(acc_r))))
    else $error("held result disagrees with PC or accumulator");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_out_valid_r, out_halted_r, out_bad_r}))
    else $error("more than one result flag set");

  a_out_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_out_valid_r) |-> (out_out_value_r == '0))
    else $error("out value nonzero without OUT");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    MOD_W'(pc_r) < PDEP)
    else $error("PC beyond program depth");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FETCH || state_r == ST_EXEC))
    else $error("result produced with no word in flight");

endmodule
